// ===== rtl/lkv_pkg.sv =====
package lkv_pkg;

   localparam int ENTRIES = 16;
   localparam int DATA_W  = 32;
   localparam int CAP_W   = 5;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int ENTRY_W = 2 * DATA_W + IDX_W;

   typedef logic [DATA_W-1:0] data_type;
   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [IDX_W:0]    thr_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [CAP_W-1:0]  cap_type;
   typedef logic [CMP_W-1:0]  cmp_type;

   localparam logic    OP_GET    = 1'b0;
   localparam logic    OP_SET    = 1'b1;
   localparam cap_type CAP_RESET = cap_type'(16);
   localparam idx_type IDX_LAST  = idx_type'(ENTRIES - 1);
   localparam thr_type THR_ALL   = thr_type'(ENTRIES);
   localparam cmp_type CMP_MAX   = cmp_type'(ENTRIES);
   localparam logic signed [DATA_W-1:0] MISS_VALUE = '1;

   typedef struct packed {
      logic                     op;
      logic signed [DATA_W-1:0] lookup_key;
      logic signed [DATA_W-1:0] write_value;
   } req_item_type;

   typedef struct packed {
      logic                     hit;
      logic signed [DATA_W-1:0] read_value;
   } rsp_item_type;

   typedef struct packed {
      data_type key;
      data_type value;
      idx_type  rank;
   } entry_type;

   typedef struct packed {
      logic     found;
      idx_type  slot;
      idx_type  slot_rank;
      data_type slot_value;
      logic     any;
      idx_type  victim;
      idx_type  worst;
      logic     free_found;
      idx_type  free_slot;
   } search_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_UPDATE,
      ST_RESP
   } state_type;

endpackage

// ===== rtl/lru_key_value_cache.sv =====
// An accepted item passes a lookup sweep and then a rank-update sweep before rsp_valid rises;
// a get that misses skips the rank pass and goes from the decision straight to the response.
// Throughput: one item at a time, next item accepted the cycle after its result loads.
// Cost is set by two sweeps over the single-port-read entry RAM: lookup, then rank update.
// Reset: valid flags and entry count clear, capacity returns to 16; RAM is not cleared.
module lru_key_value_cache (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  lkv_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output lkv_pkg::rsp_item_type rsp_item,
   input  logic                  csr_wr_en,
   input  lkv_pkg::cap_type      csr_wr_data
);

   logic                  rsp_valid_ff;
   lkv_pkg::rsp_item_type rsp_item_ff;
   logic                  rsp_free;
   logic                  rsp_load;
   lkv_pkg::rsp_item_type rsp_data;

   logic                  rd_en;
   lkv_pkg::idx_type      rd_addr;
   lkv_pkg::entry_type    rd_data;
   logic                  wr_en;
   lkv_pkg::idx_type      wr_addr;
   lkv_pkg::entry_type    wr_data;
   logic                  search_start;
   logic                  search_step;
   lkv_pkg::idx_type      search_idx;
   logic                  search_valid;
   lkv_pkg::data_type     search_key;
   lkv_pkg::search_type   sres;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   lkv_ram #(
      .WIDTH(lkv_pkg::ENTRY_W),
      .DEPTH(lkv_pkg::ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lkv_search u_search (
      .clock       (clock),
      .start       (search_start),
      .step        (search_step),
      .idx         (search_idx),
      .entry_valid (search_valid),
      .entry       (rd_data),
      .key         (search_key),
      .result      (sres)
   );

   lkv_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_item     (req_item),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .rsp_free     (rsp_free),
      .rsp_load     (rsp_load),
      .rsp_data     (rsp_data),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .search_start (search_start),
      .search_step  (search_step),
      .search_idx   (search_idx),
      .search_valid (search_valid),
      .search_key   (search_key),
      .sres         (sres)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_item_ff <= rsp_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ===== rtl/lkv_ram.sv =====
module lkv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/lkv_search.sv =====
module lkv_search (
   input  logic               clock,
   input  logic               start,
   input  logic               step,
   input  lkv_pkg::idx_type   idx,
   input  logic               entry_valid,
   input  lkv_pkg::entry_type entry,
   input  lkv_pkg::data_type  key,
   output lkv_pkg::search_type result
);

   lkv_pkg::search_type result_ff;
   lkv_pkg::search_type result_in;

   always_comb begin
      result_in = result_ff;
      if (entry_valid && !result_ff.found && entry.key == key) begin
         result_in.found      = 1'b1;
         result_in.slot       = idx;
         result_in.slot_rank  = entry.rank;
         result_in.slot_value = entry.value;
      end
      if (entry_valid && (!result_ff.any || entry.rank > result_ff.worst)) begin
         result_in.any    = 1'b1;
         result_in.victim = idx;
         result_in.worst  = entry.rank;
      end
      if (!entry_valid && !result_ff.free_found) begin
         result_in.free_found = 1'b1;
         result_in.free_slot  = idx;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         result_ff <= '0;
      end else if (step) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// ===== rtl/lkv_ctrl.sv =====
module lkv_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  lkv_pkg::req_item_type req_item,
   input  logic                  csr_wr_en,
   input  lkv_pkg::cap_type      csr_wr_data,
   input  logic                  rsp_free,
   output logic                  rsp_load,
   output lkv_pkg::rsp_item_type rsp_data,
   output logic                  rd_en,
   output lkv_pkg::idx_type      rd_addr,
   input  lkv_pkg::entry_type    rd_data,
   output logic                  wr_en,
   output lkv_pkg::idx_type      wr_addr,
   output lkv_pkg::entry_type    wr_data,
   output logic                  search_start,
   output logic                  search_step,
   output lkv_pkg::idx_type      search_idx,
   output logic                  search_valid,
   output lkv_pkg::data_type     search_key,
   input  lkv_pkg::search_type   sres
);

   lkv_pkg::state_type    state_ff, state_in;
   logic                  issue_ff;
   logic                  pend_ff;
   lkv_pkg::idx_type      addr_ff;
   lkv_pkg::idx_type      pend_idx_ff;
   logic [lkv_pkg::ENTRIES-1:0] valid_ff;
   lkv_pkg::cnt_type      count_ff;
   lkv_pkg::cap_type      cap_ff;
   lkv_pkg::req_item_type req_ff;
   lkv_pkg::idx_type      tgt_ff;
   lkv_pkg::thr_type      thr_ff;
   lkv_pkg::data_type     newval_ff;
   lkv_pkg::rsp_item_type rsp_ff;

   logic                  accept;
   logic                  phase_done;
   lkv_pkg::cmp_type      cap_ext;
   lkv_pkg::cmp_type      eff_cap;
   logic                  dec_update;
   logic                  dec_ins;
   lkv_pkg::idx_type      dec_tgt;
   lkv_pkg::thr_type      dec_thr;
   lkv_pkg::data_type     dec_val;
   lkv_pkg::rsp_item_type dec_rsp;

   assign accept     = req_valid && !req_stall;
   assign phase_done = !issue_ff && !pend_ff;

   // effective capacity: 0 acts as 1, clamp at ENTRIES
   always_comb begin
      cap_ext = lkv_pkg::cmp_type'(cap_ff);
      if (cap_ff == '0) begin
         eff_cap = lkv_pkg::cmp_type'(1);
      end else if (cap_ext > lkv_pkg::CMP_MAX) begin
         eff_cap = lkv_pkg::CMP_MAX;
      end else begin
         eff_cap = cap_ext;
      end
   end

   always_comb begin
      dec_update = 1'b1;
      dec_ins    = 1'b0;
      dec_tgt    = sres.victim;
      dec_thr    = lkv_pkg::thr_type'(sres.worst);
      dec_val    = req_ff.write_value;
      if (sres.found) begin
         dec_tgt = sres.slot;
         dec_thr = lkv_pkg::thr_type'(sres.slot_rank);
         if (req_ff.op == lkv_pkg::OP_GET) begin
            dec_val = sres.slot_value;
         end
      end else if (req_ff.op == lkv_pkg::OP_GET) begin
         dec_update = 1'b0;
      end else if ((lkv_pkg::cmp_type'(count_ff) < eff_cap && sres.free_found) ||
                   !sres.any) begin
         dec_ins = 1'b1;
         dec_tgt = sres.free_slot;
         dec_thr = lkv_pkg::THR_ALL;
      end
      dec_rsp.hit        = sres.found;
      dec_rsp.read_value = dec_update ? dec_val : lkv_pkg::MISS_VALUE;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lkv_pkg::ST_IDLE: begin
            if (accept) state_in = lkv_pkg::ST_SCAN;
         end
         lkv_pkg::ST_SCAN: begin
            if (phase_done) state_in = lkv_pkg::ST_DECIDE;
         end
         lkv_pkg::ST_DECIDE: begin
            state_in = dec_update ? lkv_pkg::ST_UPDATE : lkv_pkg::ST_RESP;
         end
         lkv_pkg::ST_UPDATE: begin
            if (phase_done) state_in = lkv_pkg::ST_RESP;
         end
         lkv_pkg::ST_RESP: begin
            if (rsp_free) state_in = lkv_pkg::ST_IDLE;
         end
         default: state_in = lkv_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall    = (state_ff != lkv_pkg::ST_IDLE);
      rd_en        = issue_ff;
      rd_addr      = addr_ff;
      search_start = accept;
      search_step  = pend_ff && (state_ff == lkv_pkg::ST_SCAN);
      search_idx   = pend_idx_ff;
      search_valid = valid_ff[pend_idx_ff];
      search_key   = req_ff.lookup_key;
      wr_en        = pend_ff && (state_ff == lkv_pkg::ST_UPDATE);
      wr_addr      = pend_idx_ff;
      wr_data      = rd_data;
      if (pend_idx_ff == tgt_ff) begin
         wr_data.key   = req_ff.lookup_key;
         wr_data.value = newval_ff;
         wr_data.rank  = '0;
      end else if (valid_ff[pend_idx_ff] &&
                   lkv_pkg::thr_type'(rd_data.rank) < thr_ff) begin
         wr_data.rank = rd_data.rank + 1'b1;
      end
      rsp_load     = (state_ff == lkv_pkg::ST_RESP) && rsp_free;
      rsp_data     = rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lkv_pkg::ST_IDLE;
         issue_ff <= 1'b0;
         pend_ff  <= 1'b0;
         valid_ff <= '0;
         count_ff <= '0;
         cap_ff   <= lkv_pkg::CAP_RESET;
      end else begin
         state_ff <= state_in;
         pend_ff  <= issue_ff;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         if (issue_ff && addr_ff == lkv_pkg::IDX_LAST) begin
            issue_ff <= 1'b0;
         end
         if (accept || (state_ff == lkv_pkg::ST_DECIDE && dec_update)) begin
            issue_ff <= 1'b1;
         end
         if (state_ff == lkv_pkg::ST_DECIDE && dec_ins) begin
            valid_ff[dec_tgt] <= 1'b1;
            count_ff          <= count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff <= addr_ff;
      if (issue_ff) begin
         addr_ff <= addr_ff + 1'b1;
      end
      if (accept || state_ff == lkv_pkg::ST_DECIDE) begin
         addr_ff <= '0;
      end
      if (accept) begin
         req_ff <= req_item;
      end
      if (state_ff == lkv_pkg::ST_DECIDE) begin
         tgt_ff    <= dec_tgt;
         thr_ff    <= dec_thr;
         newval_ff <= dec_val;
         rsp_ff    <= dec_rsp;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      lkv_pkg::cmp_type'(count_ff) <= lkv_pkg::CMP_MAX)
      else $error("entry count above ENTRIES");

   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(count_ff))
      else $error("entry count disagrees with valid flags");

   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == lkv_pkg::ST_SCAN && issue_ff)
      else $error("accepted item did not start a scan");

   a_insert_into_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lkv_pkg::ST_DECIDE && dec_ins) |-> !valid_ff[dec_tgt])
      else $error("insert targets a valid entry");
`endif

endmodule
